// File: hw/rtl/rhsl_pkg.sv
// Shared types and constants for the RGB to HSL, CMYK and luma converter.
package rhsl_pkg;

  localparam int unsigned QuoW    = 9;
  localparam int unsigned DenW    = 10;
  localparam int unsigned HueNumW = 18;
  localparam int unsigned PctNumW = 16;
  localparam int unsigned LightNumW = 17;
  localparam int unsigned LumaNumW = 19;
  localparam int unsigned ProdW   = 31;

  localparam logic [9:0]  LumaWr = 10'd299;
  localparam logic [9:0]  LumaWg = 10'd587;
  localparam logic [9:0]  LumaWb = 10'd114;
  localparam logic [LumaNumW-1:0] LumaBias = 19'd1000;
  // Reciprocals for the fixed divisors: ceil(2^23 / 255) and ceil(2^22 / 125).
  localparam logic [15:0]         Recip255 = 16'd32897;
  localparam logic [15:0]         Recip125 = 16'd33555;
  localparam logic [7:0]          DarkThresholdRst = 8'd140;

  typedef struct packed {
    logic grey;
    logic black;
    logic dark;
  } rhsl_flags_t;

  typedef struct packed {
    logic [HueNumW-1:0]   hue_n;
    logic [DenW-1:0]      hue_d;
    logic [PctNumW-1:0]   sat_n;
    logic [DenW-1:0]      sat_d;
    logic [PctNumW-1:0]   cyan_n;
    logic [PctNumW-1:0]   magenta_n;
    logic [PctNumW-1:0]   yellow_n;
    logic [DenW-1:0]      cmy_d;
    logic [PctNumW-1:0]   black_n;
    logic [LightNumW-1:0] light_n;
    logic [LumaNumW-1:0]  luma_n;
    rhsl_flags_t          flags;
  } rhsl_ops_t;

endpackage

// File: hw/rtl/rhsl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module rhsl_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 10,
  parameter int unsigned QW = 9
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned XW = NW + QW + DW;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - s;
    logic [NW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] quo_p;
    logic [XW-1:0] rem_x;
    logic [XW-1:0] den_x;
    logic          take;
    logic [QW-1:0] quo_q;

    if (s == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = g_stage[s-1].g_carry.rem_q;
      assign den_p = g_stage[s-1].g_carry.den_q;
      assign quo_p = g_stage[s-1].quo_q;
    end

    assign rem_x = XW'(rem_p);
    assign den_x = XW'(den_p) << Bit;
    assign take  = (rem_x >= den_x);

    always_ff @(posedge clk_i) begin
      quo_q <= take ? (quo_p | (QW'(1) << Bit)) : quo_p;
    end

    // The last stage only needs its quotient bit.
    if (s < QW - 1) begin : g_carry
      logic [NW-1:0] rem_q;
      logic [DW-1:0] den_q;

      always_ff @(posedge clk_i) begin
        den_q <= den_p;
        rem_q <= take ? NW'(rem_x - den_x) : rem_p;
      end
    end
  end

  assign quo_o = g_stage[QW-1].quo_q;

endmodule

// File: hw/rtl/rhsl_front.sv
// Front stages: input capture, extremes and luma sum, then divider operands.
module rhsl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic [7:0]       dark_threshold_i,
  output logic             valid_o,
  output rhsl_pkg::rhsl_ops_t ops_o
);

  logic       v1_q, v2_q, v3_q;
  logic [7:0] r1_q, g1_q, b1_q;
  logic [7:0] r2_q, g2_q, b2_q, mx2_q, mn2_q;
  logic [rhsl_pkg::LumaNumW-1:0] luma2_q;
  logic [7:0] mx_d, mn_d;
  logic [rhsl_pkg::LumaNumW-1:0] luma_d;
  rhsl_pkg::rhsl_ops_t ops_d, ops_q;

  logic [7:0]  diff;
  logic [8:0]  sum;
  logic [8:0]  sat_q9;
  logic [10:0] hue_num;

  always_comb begin
    mx_d = r1_q;
    mn_d = r1_q;
    if (g1_q > mx_d) mx_d = g1_q;
    if (b1_q > mx_d) mx_d = b1_q;
    if (g1_q < mn_d) mn_d = g1_q;
    if (b1_q < mn_d) mn_d = b1_q;
    luma_d = rhsl_pkg::LumaBias
           + (rhsl_pkg::LumaNumW'(rhsl_pkg::LumaNumW'(rhsl_pkg::LumaWr)
                                  * rhsl_pkg::LumaNumW'(r1_q)) << 1)
           + (rhsl_pkg::LumaNumW'(rhsl_pkg::LumaNumW'(rhsl_pkg::LumaWg)
                                  * rhsl_pkg::LumaNumW'(g1_q)) << 1)
           + (rhsl_pkg::LumaNumW'(rhsl_pkg::LumaNumW'(rhsl_pkg::LumaWb)
                                  * rhsl_pkg::LumaNumW'(b1_q)) << 1);
  end

  always_comb begin
    diff = mx2_q - mn2_q;
    sum  = 9'(mx2_q) + 9'(mn2_q);
    sat_q9 = (sum > 9'd255) ? 9'(10'd510 - 10'(sum)) : sum;
    priority if (mx2_q == r2_q) begin
      hue_num = (g2_q >= b2_q) ? 11'(g2_q - b2_q)
                               : 11'(11'd6 * 11'(diff) - 11'(b2_q) + 11'(g2_q));
    end else if (mx2_q == g2_q) begin
      hue_num = 11'(11'd2 * 11'(diff) + 11'(b2_q) - 11'(r2_q));
    end else begin
      hue_num = 11'(11'd4 * 11'(diff) + 11'(r2_q) - 11'(g2_q));
    end
    ops_d.hue_n     = 18'(18'd120 * 18'(hue_num)) + 18'(diff);
    ops_d.hue_d     = {1'b0, diff, 1'b0};
    ops_d.sat_n     = 16'(16'd200 * 16'(diff)) + 16'(sat_q9);
    ops_d.sat_d     = {sat_q9, 1'b0};
    ops_d.cyan_n    = 16'(16'd200 * 16'(mx2_q - r2_q)) + 16'(mx2_q);
    ops_d.magenta_n = 16'(16'd200 * 16'(mx2_q - g2_q)) + 16'(mx2_q);
    ops_d.yellow_n  = 16'(16'd200 * 16'(mx2_q - b2_q)) + 16'(mx2_q);
    ops_d.cmy_d     = {1'b0, mx2_q, 1'b0};
    ops_d.black_n   = 16'(16'd200 * 16'(8'd255 - mx2_q)) + 16'd255;
    ops_d.light_n   = 17'(17'd200 * 17'(sum)) + 17'd510;
    ops_d.luma_n    = luma2_q;
    ops_d.flags.grey  = (diff == 8'd0);
    ops_d.flags.black = (mx2_q == 8'd0);
    ops_d.flags.dark  = (sum[8:1] < dark_threshold_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q    <= red_i;
    g1_q    <= green_i;
    b1_q    <= blue_i;
    r2_q    <= r1_q;
    g2_q    <= g1_q;
    b2_q    <= b1_q;
    mx2_q   <= mx_d;
    mn2_q   <= mn_d;
    luma2_q <= luma_d;
    ops_q   <= ops_d;
  end

  assign valid_o = v3_q;
  assign ops_o   = ops_q;

endmodule

// File: hw/rtl/rgb_to_hsl_cmyk_luma.sv
// Top level of the pipelined RGB to HSL, CMYK and luma converter.
//
// Usage: drive red_i, green_i and blue_i and raise start for one cycle per
// pixel. A transaction is taken at each rising edge where start is high and
// busy is low. busy is always low: the pipeline takes one pixel every clock.
// Each result transaction appears on the result ports for exactly one cycle,
// marked by valid_o. Results leave in the order the pixels came in.
// Throughput is one pixel per cycle; each pixel passes through the three
// front stages, the nine stages of the restoring dividers (one quotient bit
// per stage) and the output register. Divisions by fixed constants use a
// reciprocal multiplication and then ride a delay line of the same depth as
// the dividers. The receiver cannot stall, so no result is ever held back.
// dark_threshold_i is written when dark_threshold_we_i is high; write it
// only while no pixel is in flight. Reset clears all valid bits, so nothing
// in flight survives, and loads the threshold with 140.
module rgb_to_hsl_cmyk_luma (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       dark_threshold_we_i,
  input  logic [7:0] dark_threshold_i,
  output logic       valid_o,
  output logic [8:0] hue_deg_o,
  output logic [6:0] sat_pct_o,
  output logic [6:0] light_pct_o,
  output logic [6:0] cyan_pct_o,
  output logic [6:0] magenta_pct_o,
  output logic [6:0] yellow_pct_o,
  output logic [6:0] black_pct_o,
  output logic [7:0] luma_o,
  output logic       is_dark_o
);

  localparam int unsigned QW = rhsl_pkg::QuoW;

  logic [7:0] thr_q;
  logic       front_valid;
  rhsl_pkg::rhsl_ops_t ops;

  // Flags, valid bits and the constant-divisor quotients ride alongside the
  // divider stages.
  logic                  dv_q [QW];
  rhsl_pkg::rhsl_flags_t fl_q [QW];
  logic [6:0]            blk_q [QW];
  logic [6:0]            lgt_q [QW];
  logic [7:0]            lum_q [QW];

  logic [QW-1:0] hue_quo, sat_quo, cyan_quo, mag_quo, yel_quo;

  logic [rhsl_pkg::ProdW-1:0] black_prod, light_prod, luma_prod;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rhsl_pkg::DarkThresholdRst;
    end else if (dark_threshold_we_i) begin
      thr_q <= dark_threshold_i;
    end
  end

  rhsl_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i          (start && !busy),
    .red_i,
    .green_i,
    .blue_i,
    .dark_threshold_i (thr_q),
    .valid_o          (front_valid),
    .ops_o            (ops)
  );

  // Every division is rounded half up by dividing 2p+q by 2q.
  rhsl_div #(.NW(rhsl_pkg::HueNumW), .DW(rhsl_pkg::DenW), .QW(QW)) u_div_hue (
    .clk_i, .num_i(ops.hue_n), .den_i(ops.hue_d), .quo_o(hue_quo));
  rhsl_div #(.NW(rhsl_pkg::PctNumW), .DW(rhsl_pkg::DenW), .QW(QW)) u_div_sat (
    .clk_i, .num_i(ops.sat_n), .den_i(ops.sat_d), .quo_o(sat_quo));
  rhsl_div #(.NW(rhsl_pkg::PctNumW), .DW(rhsl_pkg::DenW), .QW(QW)) u_div_cyan (
    .clk_i, .num_i(ops.cyan_n), .den_i(ops.cmy_d), .quo_o(cyan_quo));
  rhsl_div #(.NW(rhsl_pkg::PctNumW), .DW(rhsl_pkg::DenW), .QW(QW)) u_div_mag (
    .clk_i, .num_i(ops.magenta_n), .den_i(ops.cmy_d), .quo_o(mag_quo));
  rhsl_div #(.NW(rhsl_pkg::PctNumW), .DW(rhsl_pkg::DenW), .QW(QW)) u_div_yel (
    .clk_i, .num_i(ops.yellow_n), .den_i(ops.cmy_d), .quo_o(yel_quo));

  // Fixed divisors: 510 is 2 * 255, 1020 is 4 * 255 and 2000 is 16 * 125.
  // The low numerator bits are dropped first, then the quotient by 255 or 125
  // is taken with a reciprocal that is exact over the whole numerator range.
  assign black_prod = rhsl_pkg::ProdW'(ops.black_n[15:1])
                    * rhsl_pkg::ProdW'(rhsl_pkg::Recip255);
  assign light_prod = rhsl_pkg::ProdW'(ops.light_n[16:2])
                    * rhsl_pkg::ProdW'(rhsl_pkg::Recip255);
  assign luma_prod  = rhsl_pkg::ProdW'(ops.luma_n[18:4])
                    * rhsl_pkg::ProdW'(rhsl_pkg::Recip125);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) dv_q[i] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      dv_q[0] <= front_valid;
      for (int i = 1; i < QW; i++) dv_q[i] <= dv_q[i-1];
      valid_o <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    fl_q[0]  <= ops.flags;
    blk_q[0] <= black_prod[29:23];
    lgt_q[0] <= light_prod[29:23];
    lum_q[0] <= luma_prod[29:22];
    for (int i = 1; i < QW; i++) begin
      fl_q[i]  <= fl_q[i-1];
      blk_q[i] <= blk_q[i-1];
      lgt_q[i] <= lgt_q[i-1];
      lum_q[i] <= lum_q[i-1];
    end
  end

  // Grey pixels have no hue or saturation; black pixels have no C, M or Y.
  always_ff @(posedge clk_i) begin
    hue_deg_o     <= fl_q[QW-1].grey  ? 9'd0 : hue_quo;
    sat_pct_o     <= fl_q[QW-1].grey  ? 7'd0 : sat_quo[6:0];
    cyan_pct_o    <= fl_q[QW-1].black ? 7'd0 : cyan_quo[6:0];
    magenta_pct_o <= fl_q[QW-1].black ? 7'd0 : mag_quo[6:0];
    yellow_pct_o  <= fl_q[QW-1].black ? 7'd0 : yel_quo[6:0];
    black_pct_o   <= blk_q[QW-1];
    light_pct_o   <= lgt_q[QW-1];
    luma_o        <= lum_q[QW-1];
    is_dark_o     <= fl_q[QW-1].dark;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##13 valid_o)
    else $error("result transaction missing at the expected latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hue_deg_o <= 9'd360))
    else $error("hue out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((sat_pct_o <= 7'd100) && (light_pct_o <= 7'd100)))
    else $error("saturation or lightness out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((cyan_pct_o == 7'd0) || (magenta_pct_o == 7'd0)
                 || (yellow_pct_o == 7'd0)))
    else $error("the maximum channel must give zero ink");

endmodule

// File: verif/rgb_to_hsl_cmyk_luma_tb.sv
// Self-checking testbench for the RGB to HSL, CMYK and luma converter.
module rgb_to_hsl_cmyk_luma_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One pixel as it is handed to the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One converted color, the fields in the order of the result ports.
  typedef struct packed {
    logic [8:0] hue_deg;
    logic [6:0] sat_pct;
    logic [6:0] light_pct;
    logic [6:0] cyan_pct;
    logic [6:0] magenta_pct;
    logic [6:0] yellow_pct;
    logic [6:0] black_pct;
    logic [7:0] luma;
    logic       is_dark;
  } color_t;

  // Cycles waited after the last result is back, as margin over the pipeline.
  localparam int unsigned DrainCycles = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [7:0] red_i;
  logic [7:0] green_i;
  logic [7:0] blue_i;
  logic       dark_threshold_we_i;
  logic [7:0] dark_threshold_i;
  logic       valid_o;
  logic [8:0] hue_deg_o;
  logic [6:0] sat_pct_o;
  logic [6:0] light_pct_o;
  logic [6:0] cyan_pct_o;
  logic [6:0] magenta_pct_o;
  logic [6:0] yellow_pct_o;
  logic [6:0] black_pct_o;
  logic [7:0] luma_o;
  logic       is_dark_o;

  // Pixels waiting to be sent, and the converted colors still expected back.
  pixel_t pending_pixels[$];
  color_t expected_colors[$];

  // The predictor's own copy of the threshold register.
  logic [7:0] dark_level;

  // Percentage of cycles in which the driver holds start low.
  int unsigned gap_pct;
  int unsigned mismatches;

  rgb_to_hsl_cmyk_luma i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .dark_threshold_we_i(dark_threshold_we_i),
    .dark_threshold_i   (dark_threshold_i),
    .valid_o            (valid_o),
    .hue_deg_o          (hue_deg_o),
    .sat_pct_o          (sat_pct_o),
    .light_pct_o        (light_pct_o),
    .cyan_pct_o         (cyan_pct_o),
    .magenta_pct_o      (magenta_pct_o),
    .yellow_pct_o       (yellow_pct_o),
    .black_pct_o        (black_pct_o),
    .luma_o             (luma_o),
    .is_dark_o          (is_dark_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Rational p/q rounded to nearest, ties going up.
  function automatic int unsigned round_ratio(int unsigned p, int unsigned q);
    return (2 * p + q) / (2 * q);
  endfunction

  // Works out the converted color of one pixel under the current threshold.
  function automatic color_t convert_pixel(pixel_t px);
    color_t      res;
    int unsigned r, g, b, hi, lo, span, total, hue_num;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span = hi - lo;
    total = hi + lo;
    res = '0;
    res.light_pct = 7'(round_ratio(100 * total, 510));
    // A grey pixel has neither hue nor saturation.
    if (span != 0) begin
      if (total > 255) res.sat_pct = 7'(round_ratio(100 * span, 510 - total));
      else res.sat_pct = 7'(round_ratio(100 * span, total));
      // Ties for the maximum go to red first, then to green.
      if (hi == r) hue_num = (g >= b) ? (g - b) : (6 * span - (b - g));
      else if (hi == g) hue_num = 2 * span + b - r;
      else hue_num = 4 * span + r - g;
      res.hue_deg = 9'(round_ratio(60 * hue_num, span));
    end
    res.black_pct = 7'(round_ratio(100 * (255 - hi), 255));
    // Black leaves cyan, magenta and yellow at zero.
    if (hi != 0) begin
      res.cyan_pct    = 7'(round_ratio(100 * (hi - r), hi));
      res.magenta_pct = 7'(round_ratio(100 * (hi - g), hi));
      res.yellow_pct  = 7'(round_ratio(100 * (hi - b), hi));
    end
    res.luma = 8'(round_ratio(299 * r + 587 * g + 114 * b, 1000));
    res.is_dark = ((total >> 1) < dark_level);
    return res;
  endfunction

  // Driver: every accepted transaction is predicted at the edge that takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start   <= 1'b0;
      red_i   <= '0;
      green_i <= '0;
      blue_i  <= '0;
    end else begin
      if (start && !busy) begin
        expected_colors.push_back(convert_pixel({red_i, green_i, blue_i}));
        void'(pending_pixels.pop_front());
      end
      // Look at the queue as it will be once an accepted pixel has left it.
      if (pending_pixels.size() > 0 && $urandom_range(99) >= gap_pct) begin
        start <= 1'b1;
        {red_i, green_i, blue_i} <= pending_pixels[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    color_t got, want;
    if (rst_ni && valid_o) begin
      got = {hue_deg_o, sat_pct_o, light_pct_o, cyan_pct_o, magenta_pct_o,
             yellow_pct_o, black_pct_o, luma_o, is_dark_o};
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
      end else begin
        want = expected_colors.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Queues pixels and waits until the driver has taken all of them.
  task automatic send_pixels(input pixel_t batch[$]);
    foreach (batch[i]) pending_pixels.push_back(batch[i]);
    while (pending_pixels.size() > 0 || start) @(posedge clk_i);
  endtask

  // Waits for every expected result, then lets the pipeline drain fully.
  task automatic wait_idle();
    while (expected_colors.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes the threshold register; only called while the pipeline is empty.
  task automatic write_threshold(input logic [7:0] value);
    @(posedge clk_i);
    dark_threshold_we_i <= 1'b1;
    dark_threshold_i    <= value;
    @(posedge clk_i);
    dark_threshold_we_i <= 1'b0;
    dark_level = value;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t px;
    case ($urandom_range(5))
      0: begin
        // Grey levels.
        px.red = 8'($urandom_range(255));
        px.green = px.red;
        px.blue = px.red;
      end
      1: begin
        // Two channels are equal, which exercises the tie rules when they share the maximum.
        px.red = 8'($urandom_range(255));
        px.green = px.red;
        px.blue = 8'($urandom_range(255));
        if ($urandom_range(1)) {px.green, px.blue} = {px.blue, px.green};
      end
      2: begin
        // Channels at the extremes.
        px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(1) ? 8'hFF : 8'($urandom_range(255));
        px.blue  = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
      end
      default: px = 24'($urandom());
    endcase
    return px;
  endfunction

  initial begin
    pixel_t      batch[$];
    logic [7:0]  levels[6];
    rst_ni              = 1'b0;
    dark_threshold_we_i = 1'b0;
    dark_threshold_i    = '0;
    dark_level          = 8'd140;
    gap_pct             = 11;
    mismatches          = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pixels under the reset threshold: black, white, greys, primaries,
    // secondaries and channel ties.
    batch = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
              24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
              24'hFFFE00, 24'hFF00FE, 24'hFF00FF, 24'hFFFF01, 24'h01FFFF,
              24'hFF01FF, 24'hAA55AA, 24'h8C8C8C, 24'h8B8C8D, 24'h8D8C8B,
              24'hFFFFFE, 24'h000001, 24'h7F8081, 24'h55AAFF};
    send_pixels(batch);
    // The sender holds off until every expected result has come back.
    wait_idle();

    levels = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd200, 8'd140};
    for (int phase = 0; phase < 6; phase++) begin
      write_threshold(levels[phase]);
      if (phase == 2) gap_pct = 59;
      if (phase == 4) gap_pct = 0;
      batch.delete();
      for (int n = 0; n < 68; n++) batch.push_back(random_pixel());
      send_pixels(batch);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("rgb_to_hsl_cmyk_luma_tb passed");
    end else begin
      $display("rgb_to_hsl_cmyk_luma_tb failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("rgb_to_hsl_cmyk_luma_tb failed");
    $finish;
  end

endmodule
